// ----- hw/rtl/rcg_pkg.sv -----
// Shared types, constants and cadence tables for the ring cadence generator.
// No dependencies; every other file of the block imports this package.
package rcg_pkg;

    // Widths of fields, counters and registers.
    localparam int FUNC_W  = 2;
    localparam int STYLE_W = 3;
    localparam int POS_W   = 4;
    localparam int DUR_W   = 16;
    localparam int OSC_W   = 10;
    localparam int CNT_W   = 4;
    localparam int LEN_W   = 5;

    // Defaults for the top-level parameter and the configuration registers.
    localparam int DEFAULT_MAX_STEPS = 10;
    localparam logic [OSC_W-1:0] HALF_PERIOD_RESET = OSC_W'(25);

    // Item function codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STOP  = 2'd2,
        FUNC_LOAD  = 2'd3
    } func_t;

    // Cadence styles; codes above custom run the traditional cadence.
    typedef enum logic [STYLE_W-1:0] {
        STYLE_TRAD   = 3'd0,
        STYLE_EURO   = 3'd1,
        STYLE_PULSE  = 3'd2,
        STYLE_CONT   = 3'd3,
        STYLE_CUSTOM = 3'd4
    } style_t;

    // Configuration register contents handed to the cadence core.
    typedef struct packed {
        logic [CNT_W-1:0] custom_step_count;
        logic [OSC_W-1:0] half_period_ticks;
    } rcg_cfg_t;

    // Result of one item.
    typedef struct packed {
        logic drive;
        logic ringing;
        logic phase_on;
    } rcg_result_t;

    // Step duration in ticks of the built-in cadences.
    function automatic logic [DUR_W-1:0] builtin_duration(style_t sty, logic [POS_W-1:0] pos);
        logic [DUR_W-1:0] dur;
        case (sty)
            STYLE_EURO:
            begin
                case (pos[1:0])
                    2'd0:    dur = DUR_W'(400);
                    2'd1:    dur = DUR_W'(200);
                    2'd2:    dur = DUR_W'(400);
                    default: dur = DUR_W'(2000);
                endcase
            end
            STYLE_PULSE:
            begin
                if (pos < POS_W'(5))
                    dur = DUR_W'(200);
                else if (pos == POS_W'(5))
                    dur = DUR_W'(2500);
                else
                    dur = '0;
            end
            STYLE_CONT:
            begin
                dur = DUR_W'(1500);
            end
            default:
            begin
                dur = pos[0] ? DUR_W'(4000) : DUR_W'(2000);
            end
        endcase
        return dur;
    endfunction

    // Number of steps of the built-in cadences.
    function automatic logic [LEN_W-1:0] builtin_length(style_t sty);
        logic [LEN_W-1:0] len;
        case (sty)
            STYLE_EURO:  len = LEN_W'(4);
            STYLE_PULSE: len = LEN_W'(6);
            STYLE_CONT:  len = LEN_W'(2);
            default:     len = LEN_W'(2);
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/rcg_core.sv -----
// Cadence state and custom step table of the ring cadence generator.
// Applies one item per enabled cycle; depends on rcg_pkg.
module rcg_core
    import rcg_pkg::*;
#(
    parameter int MAX_STEPS = DEFAULT_MAX_STEPS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_en,
    input  func_t              func,
    input  logic [STYLE_W-1:0] style,
    input  logic [POS_W-1:0]   step_index,
    input  logic [DUR_W-1:0]   step_duration,
    input  rcg_cfg_t           cfg,
    output rcg_result_t        result
);

    localparam int IDX_W = $clog2(MAX_STEPS);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_STEPS);

    // Custom step durations; entries are only meaningful once loaded.
    logic [DUR_W-1:0] step_mem [MAX_STEPS];

    style_t           active_style_reg, active_style_next;
    logic             ringing_reg, ringing_next;
    logic [POS_W-1:0] step_pos_reg, step_pos_next;
    logic             on_reg, on_next;
    logic [DUR_W-1:0] step_elapsed_reg, step_elapsed_next;
    logic [OSC_W-1:0] osc_elapsed_reg, osc_elapsed_next;
    logic             osc_level_reg, osc_level_next;
    logic             pin_reg, pin_next;
    logic [LEN_W-1:0] custom_len_reg, custom_len_next;

    logic [DUR_W-1:0] custom_dur;
    logic [DUR_W-1:0] cur_dur;
    logic [LEN_W-1:0] cur_len;
    logic [LEN_W-1:0] start_len;
    logic             load_ok;

    // Current step duration and step count of the active cadence.
    always_comb
    begin
        if ({1'b0, step_pos_reg} < MAX_LEN)
            custom_dur = step_mem[step_pos_reg[IDX_W-1:0]];
        else
            custom_dur = '0;
        if (active_style_reg == STYLE_CUSTOM)
        begin
            cur_dur = custom_dur;
            cur_len = custom_len_reg;
        end
        else
        begin
            cur_dur = builtin_duration(active_style_reg, step_pos_reg);
            cur_len = builtin_length(active_style_reg);
        end
    end

    // The latched custom length is clamped to the table depth.
    assign start_len = ({1'b0, cfg.custom_step_count} > MAX_LEN) ? MAX_LEN
                                                                 : {1'b0, cfg.custom_step_count};
    assign load_ok   = ({1'b0, step_index} < MAX_LEN);

    // Next cadence state for the item in hand.
    always_comb
    begin
        logic [DUR_W-1:0] se;
        logic [OSC_W-1:0] oe;
        logic [LEN_W-1:0] pos_inc;
        logic [POS_W-1:0] pos;
        logic             on;

        active_style_next = active_style_reg;
        ringing_next      = ringing_reg;
        step_pos_next     = step_pos_reg;
        on_next           = on_reg;
        step_elapsed_next = step_elapsed_reg;
        osc_elapsed_next  = osc_elapsed_reg;
        osc_level_next    = osc_level_reg;
        pin_next          = pin_reg;
        custom_len_next   = custom_len_reg;

        se      = (step_elapsed_reg == '1) ? step_elapsed_reg : step_elapsed_reg + 1'b1;
        oe      = (osc_elapsed_reg == '1) ? osc_elapsed_reg : osc_elapsed_reg + 1'b1;
        pos_inc = {1'b0, step_pos_reg} + 1'b1;
        pos     = step_pos_reg;
        on      = on_reg;

        if (item_en)
        begin
            case (func)
                FUNC_TICK:
                begin
                    if (ringing_reg)
                    begin
                        // Step advance once the elapsed count reaches the duration.
                        if (se >= cur_dur)
                        begin
                            pos = (pos_inc >= cur_len) ? '0 : pos_inc[POS_W-1:0];
                            on  = ~pos[0];
                            se  = '0;
                        end
                        step_pos_next     = pos;
                        on_next           = on;
                        // Square wave during on steps, low during off steps.
                        if (on)
                        begin
                            if (oe >= cfg.half_period_ticks)
                            begin
                                osc_level_next = ~osc_level_reg;
                                pin_next       = ~osc_level_reg;
                                oe             = '0;
                            end
                        end
                        else
                        begin
                            pin_next = 1'b0;
                        end
                        step_elapsed_next = se;
                        osc_elapsed_next  = oe;
                    end
                end
                FUNC_START:
                begin
                    if ((style > STYLE_CUSTOM) ||
                        ((style == STYLE_CUSTOM) && (start_len == '0)))
                        active_style_next = STYLE_TRAD;
                    else
                        active_style_next = style_t'(style);
                    custom_len_next   = start_len;
                    ringing_next      = 1'b1;
                    step_pos_next     = '0;
                    on_next           = 1'b1;
                    step_elapsed_next = '0;
                    osc_elapsed_next  = '0;
                    osc_level_next    = 1'b0;
                end
                FUNC_STOP:
                begin
                    ringing_next = 1'b0;
                    on_next      = 1'b0;
                    pin_next     = 1'b0;
                end
                default:
                begin
                    // Table writes happen in the memory block below.
                end
            endcase
        end
    end

    // Custom table writes.
    always_ff @(posedge clk)
    begin
        if (item_en && (func == FUNC_LOAD) && load_ok)
            step_mem[step_index[IDX_W-1:0]] <= step_duration;
    end

    // Cadence state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_style_reg <= STYLE_TRAD;
            ringing_reg      <= 1'b0;
            step_pos_reg     <= '0;
            on_reg           <= 1'b0;
            step_elapsed_reg <= '0;
            osc_elapsed_reg  <= '0;
            osc_level_reg    <= 1'b0;
            pin_reg          <= 1'b0;
            custom_len_reg   <= '0;
        end
        else
        begin
            active_style_reg <= active_style_next;
            ringing_reg      <= ringing_next;
            step_pos_reg     <= step_pos_next;
            on_reg           <= on_next;
            step_elapsed_reg <= step_elapsed_next;
            osc_elapsed_reg  <= osc_elapsed_next;
            osc_level_reg    <= osc_level_next;
            pin_reg          <= pin_next;
            custom_len_reg   <= custom_len_next;
        end
    end

    // The result is the state after the item.
    assign result.drive    = pin_next;
    assign result.ringing  = ringing_next;
    assign result.phase_on = on_next;

endmodule

// ----- hw/rtl/ring_cadence_generator_top.sv -----
// Ring cadence generator top level: handshake stages, configuration registers.
// Depends on rcg_pkg and rcg_core.
//
// Usage: each input transfer carries one item: a one-millisecond tick, a start
// with a cadence style, a stop, or a load of one custom step duration. Every
// item yields exactly one output transfer with the bell gate level (drive),
// the ringing flag and the on-step flag as they stand after the item.
// The item is captured in the input register, then the cadence update feeds the
// result register, which raises out_valid. Throughput is one item per cycle while
// the receiver does not stall.
// When the receiver stalls, the result register holds and one more item waits
// in the input register; after that, in_stall rises until the result drains.
// Reset clears the cadence state and both stages and loads the register
// defaults (custom step count 0, half period 25 ticks). Custom step contents
// are undefined until loaded. Configuration is written over the APB-style port
// at byte address 0 (custom step count) and 4 (half period). The user must
// write it only while idle; the block itself does not enforce this.
module ring_cadence_generator_top
    import rcg_pkg::*;
#(
    parameter int MAX_STEPS = DEFAULT_MAX_STEPS
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FUNC_W-1:0]  func,
    input  logic [STYLE_W-1:0] style,
    input  logic [POS_W-1:0]   step_index,
    input  logic [DUR_W-1:0]   step_duration,
    // Output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               drive,
    output logic               ringing,
    output logic               phase_on
);

    localparam logic [2:0] ADDR_STEP_COUNT  = 3'd0;
    localparam logic [2:0] ADDR_HALF_PERIOD = 3'd4;

    logic [CNT_W-1:0]   step_count_reg;
    logic [OSC_W-1:0]   half_period_reg;
    rcg_cfg_t           cfg;
    logic               cfg_write;

    logic               in_valid_reg, in_valid_next;
    logic [FUNC_W-1:0]  func_reg;
    logic [STYLE_W-1:0] style_reg;
    logic [POS_W-1:0]   step_index_reg;
    logic [DUR_W-1:0]   step_duration_reg;

    logic               out_valid_reg, out_valid_next;
    rcg_result_t        result;
    rcg_result_t        result_reg;

    logic               advance;
    logic               item_en;

    // Configuration register writes and reads.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg  <= '0;
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr)
                ADDR_STEP_COUNT:  step_count_reg  <= pwdata[CNT_W-1:0];
                ADDR_HALF_PERIOD: half_period_reg <= pwdata[OSC_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_STEP_COUNT:  prdata = 32'(step_count_reg);
            ADDR_HALF_PERIOD: prdata = 32'(half_period_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.custom_step_count = step_count_reg;
    assign cfg.half_period_ticks = half_period_reg;

    // Flow control: the result register takes a new result when empty or draining.
    assign advance       = !out_valid_reg || !out_stall;
    assign item_en       = in_valid_reg && advance;
    assign in_stall      = in_valid_reg && !advance;
    assign in_valid_next = in_stall ? in_valid_reg : in_valid;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register captures each accepted transfer.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            func_reg          <= func;
            style_reg         <= style;
            step_index_reg    <= step_index;
            step_duration_reg <= step_duration;
        end
    end

    // Cadence state update.
    rcg_core #(
        .MAX_STEPS (MAX_STEPS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_en       (item_en),
        .func          (func_t'(func_reg)),
        .style         (style_reg),
        .step_index    (step_index_reg),
        .step_duration (step_duration_reg),
        .cfg           (cfg),
        .result        (result)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (item_en)
            result_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign drive     = result_reg.drive;
    assign ringing   = result_reg.ringing;
    assign phase_on  = result_reg.phase_on;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the ring cadence generator top level.
// Depends on rcg_pkg and ring_cadence_generator_top; a built-in cadence predictor
// checks every output transfer against the items the block has accepted.
module tb
    import rcg_pkg::*;
();

    localparam int MAX_STEPS = DEFAULT_MAX_STEPS;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] ADDR_STEP_COUNT  = 3'd0;
    localparam logic [2:0] ADDR_HALF_PERIOD = 3'd4;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 85;
    localparam int PHASE_COUNT  = 6;
    localparam int QUIET_FIRST  = 1500;
    localparam int QUIET_LAST   = 2600;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 100;
    localparam int SETTLE_TICKS = 1110;

    // One input item as it travels on the input channel.
    typedef struct {
        func_t              func;
        logic [STYLE_W-1:0] style;
        logic [POS_W-1:0]   step_index;
        logic [DUR_W-1:0]   step_duration;
    } ring_item_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [FUNC_W-1:0]  func = '0;
    logic [STYLE_W-1:0] style = '0;
    logic [POS_W-1:0]   step_index = '0;
    logic [DUR_W-1:0]   step_duration = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               drive;
    logic               ringing;
    logic               phase_on;

    // Stimulus backlog and the bell levels still owed by the block.
    ring_item_t  item_backlog [$];
    rcg_result_t bell_expected [$];
    ring_item_t  drv_item;
    rcg_result_t bell_want;

    int errors = 0;
    int results_seen = 0;
    int cyc = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // Phase settings: step count and half period, extremes included.
    int phase_steps [PHASE_COUNT] = '{10, 1, 15, 2, 3, 0};
    int phase_half  [PHASE_COUNT] = '{1, 0, 2, 1023, 25, 1000};

    // Predictor copy of the configuration and the cadence state.
    logic [CNT_W-1:0] cfg_steps = '0;
    logic [OSC_W-1:0] cfg_half = HALF_PERIOD_RESET;
    logic [DUR_W-1:0] step_ms [MAX_STEPS];
    style_t           cad_style = STYLE_TRAD;
    logic [LEN_W-1:0] cad_len = '0;
    logic [POS_W-1:0] cad_pos = '0;
    logic [DUR_W-1:0] cad_ms = '0;
    logic [OSC_W-1:0] tone_ms = '0;
    logic             tone_level = 1'b0;
    logic             gate_level = 1'b0;
    logic             bell_ringing = 1'b0;
    logic             bell_on = 1'b0;

    wire quiet = (cyc >= QUIET_FIRST) && (cyc < QUIET_LAST);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    ring_cadence_generator_top #(
        .MAX_STEPS(MAX_STEPS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .style(style),
        .step_index(step_index),
        .step_duration(step_duration),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .drive(drive),
        .ringing(ringing),
        .phase_on(phase_on)
    );

    function automatic ring_item_t make_item(func_t f, logic [STYLE_W-1:0] s,
                                             logic [POS_W-1:0] idx, logic [DUR_W-1:0] dur);
        ring_item_t it;
        it.func = f;
        it.style = s;
        it.step_index = idx;
        it.step_duration = dur;
        return it;
    endfunction

    // Duration in ticks of the given step of the running cadence.
    function automatic logic [DUR_W-1:0] cadence_ms(logic [POS_W-1:0] pos);
        logic [DUR_W-1:0] ms;
        case (cad_style)
            STYLE_EURO:   ms = (pos[1:0] == 2'd1) ? 16'd200 :
                               (pos[1:0] == 2'd3) ? 16'd2000 : 16'd400;
            STYLE_PULSE:  ms = (pos < 4'd5) ? 16'd200 : (pos == 4'd5) ? 16'd2500 : 16'd0;
            STYLE_CONT:   ms = 16'd1500;
            STYLE_CUSTOM: ms = (int'(pos) < MAX_STEPS) ? step_ms[pos] : 16'd0;
            default:      ms = pos[0] ? 16'd4000 : 16'd2000;
        endcase
        return ms;
    endfunction

    // Number of steps in the running cadence.
    function automatic int cadence_len();
        int n;
        case (cad_style)
            STYLE_EURO:   n = 4;
            STYLE_PULSE:  n = 6;
            STYLE_CUSTOM: n = int'(cad_len);
            default:      n = 2;
        endcase
        return n;
    endfunction

    // Advance the predicted bell state by one item and return the levels after it.
    function automatic rcg_result_t predict_bell(ring_item_t it);
        rcg_result_t res;
        logic [LEN_W-1:0] n;
        case (it.func)
            FUNC_TICK:
            begin
                if (bell_ringing)
                begin
                    if (cad_ms != '1)
                        cad_ms = cad_ms + 1'b1;
                    if (tone_ms != '1)
                        tone_ms = tone_ms + 1'b1;
                    if (cad_ms >= cadence_ms(cad_pos))
                    begin
                        if (int'(cad_pos) + 1 >= cadence_len())
                            cad_pos = '0;
                        else
                            cad_pos = cad_pos + 1'b1;
                        bell_on = ~cad_pos[0];
                        cad_ms = '0;
                    end
                    if (bell_on)
                    begin
                        if (tone_ms >= cfg_half)
                        begin
                            tone_level = ~tone_level;
                            gate_level = tone_level;
                            tone_ms = '0;
                        end
                    end
                    else
                    begin
                        gate_level = 1'b0;
                    end
                end
            end
            FUNC_START:
            begin
                n = (int'(cfg_steps) > MAX_STEPS) ? LEN_W'(MAX_STEPS) : LEN_W'(cfg_steps);
                // Unknown styles and an empty custom table both fall back to traditional.
                if (it.style > STYLE_CUSTOM || (it.style == STYLE_CUSTOM && n == '0))
                    cad_style = STYLE_TRAD;
                else
                    cad_style = style_t'(it.style);
                cad_len = n;
                bell_ringing = 1'b1;
                cad_pos = '0;
                bell_on = 1'b1;
                cad_ms = '0;
                tone_ms = '0;
                tone_level = 1'b0;
            end
            FUNC_STOP:
            begin
                bell_ringing = 1'b0;
                bell_on = 1'b0;
                gate_level = 1'b0;
            end
            default:
            begin
                if (int'(it.step_index) < MAX_STEPS)
                    step_ms[it.step_index] = it.step_duration;
            end
        endcase
        res.drive = gate_level;
        res.ringing = bell_ringing;
        res.phase_on = bell_on;
        return res;
    endfunction

    // Random item: mostly ticks, with starts biased to custom and short loaded steps.
    function automatic ring_item_t random_item();
        ring_item_t it;
        int pick;
        it = make_item(FUNC_TICK, STYLE_W'($urandom), POS_W'($urandom), DUR_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick >= 70 && pick < 80)
        begin
            it.func = FUNC_START;
            if ($urandom_range(0, 99) < 40)
                it.style = STYLE_CUSTOM;
        end
        else if (pick >= 80 && pick < 85)
        begin
            it.func = FUNC_STOP;
        end
        else if (pick >= 85)
        begin
            it.func = FUNC_LOAD;
            if ($urandom_range(0, 99) < 10)
                it.step_index = POS_W'($urandom_range(10, 15));
            else
                it.step_index = POS_W'($urandom_range(0, MAX_STEPS - 1));
            pick = $urandom_range(0, 99);
            if (pick < 80)
                it.step_duration = DUR_W'($urandom_range(0, 6));
            else if (pick < 90)
                it.step_duration = DUR_W'($urandom_range(0, 300));
        end
        return it;
    endfunction

    // Write one register over the configuration port and mirror it in the predictor.
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_STEP_COUNT)
            cfg_steps = data[CNT_W-1:0];
        else
            cfg_half = data[OSC_W-1:0];
    endtask

    // Wait until every pending item has been transferred and every result returned.
    task automatic wait_idle();
        @(posedge clk);
        while (item_backlog.size() != 0 || in_valid || bell_expected.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Input driver: a new item goes out only when the current one has been transferred.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (item_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= 33))
            begin
                drv_item = item_backlog.pop_front();
                in_valid <= 1'b1;
                func <= drv_item.func;
                style <= drv_item.style;
                step_index <= drv_item.step_index;
                step_duration <= drv_item.step_duration;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off so the block backs up its input.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !quiet && ($urandom_range(0, 99) < 33);
        end
    end

    // Monitor: predict on each input transfer, check each output transfer in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                bell_expected.push_back(predict_bell(make_item(func_t'(func), style,
                                                               step_index, step_duration)));
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (bell_expected.size() == 0)
                begin
                    errors++;
                    $error("output transfer with no expected result waiting");
                end
                else
                begin
                    bell_want = bell_expected.pop_front();
                    if (drive !== bell_want.drive)
                    begin
                        errors++;
                        $error("drive: expected %0b, got %0b", bell_want.drive, drive);
                    end
                    if (ringing !== bell_want.ringing)
                    begin
                        errors++;
                        $error("ringing: expected %0b, got %0b", bell_want.ringing, ringing);
                    end
                    if (phase_on !== bell_want.phase_on)
                    begin
                        errors++;
                        $error("phase_on: expected %0b, got %0b", bell_want.phase_on, phase_on);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: directed opening, then one random phase per register setting.
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Idle tick and stop change nothing.
        item_backlog.push_back(make_item(FUNC_TICK, STYLE_W'($urandom), POS_W'($urandom),
                                         DUR_W'($urandom)));
        item_backlog.push_back(make_item(FUNC_STOP, STYLE_W'($urandom), POS_W'($urandom),
                                         DUR_W'($urandom)));
        // Fill the whole custom table, a zero step and a maximum step among them.
        item_backlog.push_back(make_item(FUNC_LOAD, 3'd7, 4'd0, 16'd2));
        item_backlog.push_back(make_item(FUNC_LOAD, 3'd0, 4'd1, 16'd0));
        item_backlog.push_back(make_item(FUNC_LOAD, 3'd5, 4'd2, 16'd1));
        item_backlog.push_back(make_item(FUNC_LOAD, 3'd2, 4'd3, 16'd3));
        item_backlog.push_back(make_item(FUNC_LOAD, 3'd1, 4'd4, 16'd1));
        item_backlog.push_back(make_item(FUNC_LOAD, 3'd6, 4'd5, 16'd2));
        item_backlog.push_back(make_item(FUNC_LOAD, 3'd3, 4'd6, 16'd1));
        item_backlog.push_back(make_item(FUNC_LOAD, 3'd4, 4'd7, 16'd2));
        item_backlog.push_back(make_item(FUNC_LOAD, 3'd7, 4'd8, 16'd1));
        item_backlog.push_back(make_item(FUNC_LOAD, 3'd0, 4'd9, 16'hFFFF));
        // Loads beyond the table are ignored.
        item_backlog.push_back(make_item(FUNC_LOAD, 3'd7, 4'd10, 16'hFFFF));
        item_backlog.push_back(make_item(FUNC_LOAD, 3'd0, 4'd15, 16'h0000));
        // Custom with no steps and an unknown style both run traditional.
        item_backlog.push_back(make_item(FUNC_START, STYLE_CUSTOM, 4'd15, 16'hFFFF));
        item_backlog.push_back(make_item(FUNC_TICK, 3'd7, 4'd15, 16'hFFFF));
        item_backlog.push_back(make_item(FUNC_START, 3'd7, 4'd0, 16'd0));
        item_backlog.push_back(make_item(FUNC_TICK, 3'd0, 4'd0, 16'd0));
        item_backlog.push_back(make_item(FUNC_START, STYLE_EURO, POS_W'($urandom), 16'd0));
        item_backlog.push_back(make_item(FUNC_TICK, STYLE_W'($urandom), 4'd0, 16'd0));
        item_backlog.push_back(make_item(FUNC_START, STYLE_PULSE, POS_W'($urandom), 16'd0));
        item_backlog.push_back(make_item(FUNC_TICK, STYLE_W'($urandom), 4'd0, 16'd0));
        item_backlog.push_back(make_item(FUNC_START, STYLE_CONT, POS_W'($urandom), 16'd0));
        item_backlog.push_back(make_item(FUNC_TICK, STYLE_W'($urandom), 4'd0, 16'd0));
        item_backlog.push_back(make_item(FUNC_STOP, STYLE_W'($urandom), 4'd0, 16'd0));

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_idle();
            write_reg(ADDR_STEP_COUNT, 32'(phase_steps[p]));
            write_reg(ADDR_HALF_PERIOD, 32'(phase_half[p]));
            // A long off step lets the oscillator count saturate before the next on step.
            if (phase_half[p] == 1023)
            begin
                item_backlog.push_back(make_item(FUNC_LOAD, 3'd0, 4'd0, 16'd4));
                item_backlog.push_back(make_item(FUNC_LOAD, 3'd0, 4'd1, 16'd1100));
                item_backlog.push_back(make_item(FUNC_START, STYLE_CUSTOM, 4'd0, 16'd0));
                for (int t = 0; t < SETTLE_TICKS; t++)
                    item_backlog.push_back(make_item(FUNC_TICK, STYLE_W'($urandom),
                                                     POS_W'($urandom), DUR_W'($urandom)));
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                item_backlog.push_back(random_item());
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/rcg_pkg.sv
hw/rtl/rcg_core.sv
hw/rtl/ring_cadence_generator_top.sv
dv/tb.sv
